/* hdl/assert_macros.svh */
// Assertion macros used by the checker file ubx_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, suspended while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/ubx_pkg.sv */
`default_nettype none

package ubx_pkg;

   localparam logic [7:0]  SYNC_FIRST   = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND  = 8'h62;
   localparam logic [7:0]  NAV_CLASS    = 8'h01;
   localparam logic [7:0]  PVT_ID       = 8'h07;
   localparam logic [15:0] PVT_LEN      = 16'd92;
   localparam logic [7:0]  MIN_FIX      = 8'd2;
   localparam logic [6:0]  FIX_TYPE_OFF = 7'd20;
   localparam logic [6:0]  FLAGS_OFF    = 7'd21;
   localparam logic [4:0]  LAST_FIELD   = 5'd31;
   localparam logic [5:0]  FIX_INDEX    = 6'd32;

   localparam logic [1:0]  SIZE_1 = 2'd0;
   localparam logic [1:0]  SIZE_2 = 2'd1;
   localparam logic [1:0]  SIZE_4 = 2'd3;

   typedef struct packed {
      logic [6:0] off;
      logic [1:0] size_m1;
      logic       sgn;
   } field_desc_type;

   typedef struct packed {
      logic clear;
      logic sum_clear;
      logic ld_class;
      logic ld_id;
      logic ld_len_lo;
      logic ld_len_hi;
      logic pay_wr;
      logic emit_start;
      logic rd_en;
      logic acc_cap;
      logic byte_next;
      logic field_next;
      logic out_load_field;
      logic out_load_fix;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_sync1;
      logic is_sync2;
      logic len_zero;
      logic len_over;
      logic pay_last;
      logic cka_ok;
      logic ckb_good;
      logic fld_last_byte;
      logic fld_last;
      logic out_taken;
   } dp_status_type;

   function automatic field_desc_type field_desc(input logic [4:0] k);
      field_desc_type d;
      unique case (k)
         5'd0:    d = '{7'd0,  SIZE_4, 1'b0};
         5'd1:    d = '{7'd4,  SIZE_2, 1'b0};
         5'd2:    d = '{7'd6,  SIZE_1, 1'b0};
         5'd3:    d = '{7'd7,  SIZE_1, 1'b0};
         5'd4:    d = '{7'd8,  SIZE_1, 1'b0};
         5'd5:    d = '{7'd9,  SIZE_1, 1'b0};
         5'd6:    d = '{7'd10, SIZE_1, 1'b0};
         5'd7:    d = '{7'd11, SIZE_1, 1'b0};
         5'd8:    d = '{7'd12, SIZE_4, 1'b0};
         5'd9:    d = '{7'd16, SIZE_4, 1'b1};
         5'd10:   d = '{7'd20, SIZE_1, 1'b0};
         5'd11:   d = '{7'd21, SIZE_1, 1'b0};
         5'd12:   d = '{7'd22, SIZE_1, 1'b0};
         5'd13:   d = '{7'd23, SIZE_1, 1'b0};
         5'd14:   d = '{7'd24, SIZE_4, 1'b1};
         5'd15:   d = '{7'd28, SIZE_4, 1'b1};
         5'd16:   d = '{7'd32, SIZE_4, 1'b1};
         5'd17:   d = '{7'd36, SIZE_4, 1'b1};
         5'd18:   d = '{7'd40, SIZE_4, 1'b0};
         5'd19:   d = '{7'd44, SIZE_4, 1'b0};
         5'd20:   d = '{7'd48, SIZE_4, 1'b1};
         5'd21:   d = '{7'd52, SIZE_4, 1'b1};
         5'd22:   d = '{7'd56, SIZE_4, 1'b1};
         5'd23:   d = '{7'd60, SIZE_4, 1'b1};
         5'd24:   d = '{7'd64, SIZE_4, 1'b1};
         5'd25:   d = '{7'd68, SIZE_4, 1'b0};
         5'd26:   d = '{7'd72, SIZE_4, 1'b0};
         5'd27:   d = '{7'd76, SIZE_2, 1'b0};
         5'd28:   d = '{7'd78, SIZE_1, 1'b0};
         5'd29:   d = '{7'd84, SIZE_4, 1'b1};
         5'd30:   d = '{7'd88, SIZE_2, 1'b1};
         5'd31:   d = '{7'd90, SIZE_2, 1'b0};
         default: d = '{7'd0,  SIZE_4, 1'b0};
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

/* hdl/ubx_nav_pvt_deframer.sv */
// UBX deframer with NAV-PVT field decoder.
// The req channel carries one received byte per beat. The parser hunts for the
// sync pair, reads class, id and length, stores the payload in a 92-byte RAM and
// checks the 8-bit Fletcher checksum. Frames that fail the check, are too long or
// are not NAV-PVT produce no output.
// req_tready is high while the parser hunts for sync or receives a frame.
// After the beat that carries CK_B of a good NAV-PVT frame, req_tready drops and
// the block reads the payload RAM a byte at a time (address, then data),
// sending 33 rsp beats: fields 0 to 31 on tuser, then the valid-fix flag with
// tlast set. The parser takes no new byte until the last beat is taken.
// Each rsp beat waits in the output register until rsp_tready is high; a stall
// simply holds the beat and delays the rest of the run.
// Synchronous reset returns the parser to the sync hunt and drops rsp_tvalid.
// The payload RAM is not cleared; only bytes of the current frame are read.
`default_nettype none

module ubx_nav_pvt_deframer
   import ubx_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 92
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [32:0] field_value, [39:33] zero
   output logic [5:0]  rsp_tuser,   // [5:0] field_index
   output logic        rsp_tlast
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   ubx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ubx_dp #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .rx_byte   (req_tdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

`default_nettype wire

/* hdl/ubx_ram.sv */
`default_nettype none

module ubx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 92
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/ubx_ctrl.sv */
`default_nettype none

module ubx_ctrl
   import ubx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   localparam logic [3:0] ST_SYNC1    = 4'd0;
   localparam logic [3:0] ST_SYNC2    = 4'd1;
   localparam logic [3:0] ST_CLASS    = 4'd2;
   localparam logic [3:0] ST_ID       = 4'd3;
   localparam logic [3:0] ST_LEN_LO   = 4'd4;
   localparam logic [3:0] ST_LEN_HI   = 4'd5;
   localparam logic [3:0] ST_PAYLOAD  = 4'd6;
   localparam logic [3:0] ST_CK_A     = 4'd7;
   localparam logic [3:0] ST_CK_B     = 4'd8;
   localparam logic [3:0] ST_EMIT_RD  = 4'd9;
   localparam logic [3:0] ST_EMIT_ACC = 4'd10;
   localparam logic [3:0] ST_EMIT_OUT = 4'd11;
   localparam logic [3:0] ST_EMIT_FIX = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       take;

   assign req_tready = (state_ff <= ST_CK_B);
   assign take       = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_SYNC1: begin
            if (take && sts.is_sync1) begin
               state_in = ST_SYNC2;
            end
         end
         ST_SYNC2: begin
            if (take) begin
               if (sts.is_sync2) begin
                  cmd.sum_clear = 1'b1;
                  state_in      = ST_CLASS;
               end else if (!sts.is_sync1) begin
                  state_in = ST_SYNC1;
               end
            end
         end
         ST_CLASS: begin
            if (take) begin
               cmd.ld_class = 1'b1;
               state_in     = ST_ID;
            end
         end
         ST_ID: begin
            if (take) begin
               cmd.ld_id = 1'b1;
               state_in  = ST_LEN_LO;
            end
         end
         ST_LEN_LO: begin
            if (take) begin
               cmd.ld_len_lo = 1'b1;
               state_in      = ST_LEN_HI;
            end
         end
         ST_LEN_HI: begin
            if (take) begin
               cmd.ld_len_hi = 1'b1;
               if (sts.len_zero) begin
                  state_in = ST_CK_A;
               end else if (sts.len_over) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_SYNC1;
               end else begin
                  state_in = ST_PAYLOAD;
               end
            end
         end
         ST_PAYLOAD: begin
            if (take) begin
               cmd.pay_wr = 1'b1;
               if (sts.pay_last) begin
                  state_in = ST_CK_A;
               end
            end
         end
         ST_CK_A: begin
            if (take) begin
               if (sts.cka_ok) begin
                  state_in = ST_CK_B;
               end else begin
                  cmd.clear = 1'b1;
                  state_in  = ST_SYNC1;
               end
            end
         end
         ST_CK_B: begin
            if (take) begin
               cmd.clear = 1'b1;
               if (sts.ckb_good) begin
                  cmd.emit_start = 1'b1;
                  state_in       = ST_EMIT_RD;
               end else begin
                  state_in = ST_SYNC1;
               end
            end
         end
         ST_EMIT_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EMIT_ACC;
         end
         ST_EMIT_ACC: begin
            if (sts.fld_last_byte) begin
               cmd.out_load_field = 1'b1;
               state_in           = ST_EMIT_OUT;
            end else begin
               cmd.acc_cap   = 1'b1;
               cmd.byte_next = 1'b1;
               state_in      = ST_EMIT_RD;
            end
         end
         ST_EMIT_OUT: begin
            if (sts.out_taken) begin
               if (sts.fld_last) begin
                  cmd.out_load_fix = 1'b1;
                  state_in         = ST_EMIT_FIX;
               end else begin
                  cmd.field_next = 1'b1;
                  state_in       = ST_EMIT_RD;
               end
            end
         end
         ST_EMIT_FIX: begin
            if (sts.out_taken) begin
               state_in = ST_SYNC1;
            end
         end
         default: begin
            cmd.clear = 1'b1;
            state_in  = ST_SYNC1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SYNC1;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/ubx_dp.sv */
`default_nettype none

module ubx_dp
   import ubx_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 92
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    rx_byte,
   input  ctrl_cmd_type  cmd,
   output dp_status_type sts,
   input  logic          rsp_tready,
   output logic          rsp_tvalid,
   output logic [39:0]   rsp_tdata,
   output logic [5:0]    rsp_tuser,
   output logic          rsp_tlast
);

   localparam int AW = $clog2(PAYLOAD_BYTES);

   logic [7:0]     msg_class_ff, msg_class_in;
   logic [7:0]     msg_id_ff, msg_id_in;
   logic [15:0]    msg_length_ff, msg_length_in;
   logic [AW-1:0]  byte_count_ff, byte_count_in;
   logic [7:0]     sum_a_ff, sum_a_in;
   logic [7:0]     sum_b_ff, sum_b_in;
   logic [7:0]     fix_type_ff, fix_type_in;
   logic           flag0_ff, flag0_in;
   logic [4:0]     field_ff, field_in;
   logic [1:0]     byte_sel_ff, byte_sel_in;
   logic [31:0]    acc_ff, acc_in;
   logic           out_valid_ff, out_valid_in;
   logic [32:0]    out_value_ff, out_value_in;
   logic [5:0]     out_index_ff, out_index_in;
   logic           out_last_ff, out_last_in;

   logic [7:0]     add_a;
   logic [7:0]     add_b;
   logic           do_sum;
   logic [15:0]    len_full;
   logic [AW:0]    count_next;
   field_desc_type desc;
   logic [AW-1:0]  rd_addr;
   logic [7:0]     rd_data;
   logic [31:0]    word;
   logic [32:0]    ext;

   ubx_ram #(
      .WIDTH(8),
      .DEPTH(PAYLOAD_BYTES)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.pay_wr),
      .wr_addr(byte_count_ff),
      .wr_data(rx_byte),
      .rd_en  (cmd.rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign desc       = field_desc(field_ff);
   assign rd_addr    = AW'(desc.off + {5'd0, byte_sel_ff});
   assign len_full   = {rx_byte, msg_length_ff[7:0]};
   assign count_next = {1'b0, byte_count_ff} + 1'b1;
   assign do_sum     = cmd.ld_class || cmd.ld_id || cmd.ld_len_lo || cmd.ld_len_hi
                       || cmd.pay_wr;
   assign add_a      = sum_a_ff + rx_byte;
   assign add_b      = sum_b_ff + add_a;

   always_comb begin
      word = acc_ff;
      case (byte_sel_ff)
         2'd0:    word[7:0]   = rd_data;
         2'd1:    word[15:8]  = rd_data;
         2'd2:    word[23:16] = rd_data;
         default: word[31:24] = rd_data;
      endcase
      case (desc.size_m1)
         SIZE_1:  ext = {{25{desc.sgn & word[7]}}, word[7:0]};
         SIZE_2:  ext = {{17{desc.sgn & word[15]}}, word[15:0]};
         default: ext = {desc.sgn & word[31], word};
      endcase
   end

   always_comb begin
      sts.is_sync1      = (rx_byte == SYNC_FIRST);
      sts.is_sync2      = (rx_byte == SYNC_SECOND);
      sts.len_zero      = (len_full == 16'd0);
      sts.len_over      = (len_full > 16'(PAYLOAD_BYTES));
      sts.pay_last      = (16'(count_next) >= msg_length_ff)
                          || (count_next >= (AW+1)'(PAYLOAD_BYTES));
      sts.cka_ok        = (rx_byte == sum_a_ff);
      sts.ckb_good      = (rx_byte == sum_b_ff) && (msg_class_ff == NAV_CLASS)
                          && (msg_id_ff == PVT_ID) && (msg_length_ff == PVT_LEN);
      sts.fld_last_byte = (byte_sel_ff == desc.size_m1);
      sts.fld_last      = (field_ff == LAST_FIELD);
      sts.out_taken     = out_valid_ff && rsp_tready;
   end

   always_comb begin
      msg_class_in  = msg_class_ff;
      msg_id_in     = msg_id_ff;
      msg_length_in = msg_length_ff;
      byte_count_in = byte_count_ff;
      sum_a_in      = sum_a_ff;
      sum_b_in      = sum_b_ff;
      fix_type_in   = fix_type_ff;
      flag0_in      = flag0_ff;
      field_in      = field_ff;
      byte_sel_in   = byte_sel_ff;
      acc_in        = acc_ff;
      out_value_in  = out_value_ff;
      out_index_in  = out_index_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;

      if (do_sum) begin
         sum_a_in = add_a;
         sum_b_in = add_b;
      end
      if (cmd.sum_clear) begin
         sum_a_in = 8'd0;
         sum_b_in = 8'd0;
      end
      if (cmd.ld_class) begin
         msg_class_in = rx_byte;
      end
      if (cmd.ld_id) begin
         msg_id_in = rx_byte;
      end
      if (cmd.ld_len_lo) begin
         msg_length_in = {8'd0, rx_byte};
      end
      if (cmd.ld_len_hi) begin
         msg_length_in = len_full;
         byte_count_in = '0;
      end
      if (cmd.pay_wr) begin
         byte_count_in = count_next[AW-1:0];
         if (7'(byte_count_ff) == FIX_TYPE_OFF) begin
            fix_type_in = rx_byte;
         end
         if (7'(byte_count_ff) == FLAGS_OFF) begin
            flag0_in = rx_byte[0];
         end
      end
      if (cmd.clear) begin
         msg_class_in  = 8'd0;
         msg_id_in     = 8'd0;
         msg_length_in = 16'd0;
         byte_count_in = '0;
         sum_a_in      = 8'd0;
         sum_b_in      = 8'd0;
      end

      if (cmd.emit_start) begin
         field_in    = 5'd0;
         byte_sel_in = 2'd0;
      end
      if (cmd.acc_cap) begin
         acc_in = word;
      end
      if (cmd.byte_next) begin
         byte_sel_in = byte_sel_ff + 2'd1;
      end
      if (cmd.field_next) begin
         field_in    = field_ff + 5'd1;
         byte_sel_in = 2'd0;
      end
      if (cmd.out_load_field) begin
         out_valid_in = 1'b1;
         out_value_in = ext;
         out_index_in = {1'b0, field_ff};
         out_last_in  = 1'b0;
      end
      if (cmd.out_load_fix) begin
         out_valid_in = 1'b1;
         out_value_in = {32'd0, (fix_type_ff >= MIN_FIX) && flag0_ff};
         out_index_in = FIX_INDEX;
         out_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_class_ff  <= 8'd0;
         msg_id_ff     <= 8'd0;
         msg_length_ff <= 16'd0;
         byte_count_ff <= '0;
         sum_a_ff      <= 8'd0;
         sum_b_ff      <= 8'd0;
         field_ff      <= 5'd0;
         byte_sel_ff   <= 2'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         msg_class_ff  <= msg_class_in;
         msg_id_ff     <= msg_id_in;
         msg_length_ff <= msg_length_in;
         byte_count_ff <= byte_count_in;
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         field_ff      <= field_in;
         byte_sel_ff   <= byte_sel_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fix_type_ff  <= fix_type_in;
      flag0_ff     <= flag0_in;
      acc_ff       <= acc_in;
      out_value_ff <= out_value_in;
      out_index_ff <= out_index_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_value_ff};
   assign rsp_tuser  = out_index_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

/* hdl/ubx_chk.sv */
`default_nettype none
`include "assert_macros.svh"

module ubx_chk
   import ubx_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [5:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic req_beat;
   logic rsp_beat;
   logic rsp_stall;
   logic last_ok;

   assign req_beat  = req_tvalid && req_tready;
   assign rsp_beat  = rsp_tvalid && rsp_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign last_ok   = (rsp_tuser == FIX_INDEX) && (rsp_tdata[39:1] == 39'd0);

   `ASSERT_CLK(a_reset_drops_valid, clock,
      reset |=> !rsp_tvalid, "rsp_tvalid after reset")
   `ASSERT_CLK_RST(a_no_input_while_sending, clock, reset,
      rsp_tvalid |-> !req_beat, "input taken while a result waits")
   `ASSERT_CLK_RST(a_last_is_fix_flag, clock, reset,
      (rsp_tvalid && rsp_tlast) |-> last_ok, "bad final beat")
   `ASSERT_CLK_RST(a_run_ends, clock, reset,
      (rsp_beat && rsp_tlast) |=> !rsp_tvalid, "beat after end of run")
   `ASSERT_CLK_RST(a_stall_holds, clock, reset,
      rsp_stall |=> (rsp_tvalid && $stable({rsp_tdata, rsp_tuser})), "stalled beat changed")

endmodule

bind ubx_nav_pvt_deframer ubx_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);

`default_nettype wire

/* tb/sv/ubx_nav_pvt_deframer_checker.sv */
`timescale 1ns / 1ps

module ubx_nav_pvt_deframer_checker
   import ubx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [5:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          error_count,
   output int          fields_pending
);

   localparam int PAYLOAD_BYTES = 92;
   localparam int NUM_FIELDS    = 32;

   // Payload layout of a NAV-PVT message, one entry per decoded field.
   localparam logic [0:31][6:0] FIELD_OFFSET = {
      7'd0,  7'd4,  7'd6,  7'd7,  7'd8,  7'd9,  7'd10, 7'd11,
      7'd12, 7'd16, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd28,
      7'd32, 7'd36, 7'd40, 7'd44, 7'd48, 7'd52, 7'd56, 7'd60,
      7'd64, 7'd68, 7'd72, 7'd76, 7'd78, 7'd84, 7'd88, 7'd90
   };
   localparam logic [0:31][2:0] FIELD_BYTES = {
      3'd4, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd4, 3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd4, 3'd4,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd4, 3'd4, 3'd4, 3'd2, 3'd1, 3'd4, 3'd2, 3'd2
   };
   localparam logic [0:31] FIELD_SIGNED = 32'b00000000_01000011_11001111_10000110;

   typedef enum logic [3:0] {
      HUNT_SYNC1, HUNT_SYNC2, GET_CLASS, GET_ID, GET_LEN_LO, GET_LEN_HI,
      GET_PAYLOAD, CHECK_CK_A, CHECK_CK_B
   } parse_phase_e;

   typedef struct packed {
      logic [5:0]  index;
      logic [32:0] value;
      logic        last;
   } pvt_field_t;

   parse_phase_e phase;
   logic [7:0]   frame_class;
   logic [7:0]   frame_id;
   logic [15:0]  frame_len;
   logic [6:0]   byte_count;
   logic [7:0]   sum_a;
   logic [7:0]   sum_b;
   logic [7:0]   payload [0:PAYLOAD_BYTES-1];
   pvt_field_t   expected_fields [$];
   pvt_field_t   field;
   logic [63:0]  raw;
   int           size;

   task automatic clear_parser();
      phase       = HUNT_SYNC1;
      frame_class = '0;
      frame_id    = '0;
      frame_len   = '0;
      byte_count  = '0;
      sum_a       = '0;
      sum_b       = '0;
   endtask

   task automatic add_to_checksum(input logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         expected_fields.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_fields.size() == 0) begin
               error_count++;
               $display("%0t: unexpected field beat: index %0d value %h last %b",
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
            end else begin
               field = expected_fields.pop_front();
               if (rsp_tuser != field.index || rsp_tdata != {7'd0, field.value} ||
                   rsp_tlast != field.last) begin
                  error_count++;
                  $display("%0t: field beat mismatch: expected index %0d value %h last %b, got index %0d value %h last %b",
                           $time, field.index, {7'd0, field.value}, field.last,
                           rsp_tuser, rsp_tdata, rsp_tlast);
               end
            end
         end

         if (req_tvalid && req_tready) begin
            case (phase)
               HUNT_SYNC1: begin
                  if (req_tdata == SYNC_FIRST) phase = HUNT_SYNC2;
               end
               HUNT_SYNC2: begin
                  if (req_tdata == SYNC_SECOND) begin
                     phase = GET_CLASS;
                     sum_a = '0;
                     sum_b = '0;
                  end else if (req_tdata != SYNC_FIRST) begin
                     phase = HUNT_SYNC1;
                  end
               end
               GET_CLASS: begin
                  frame_class = req_tdata;
                  add_to_checksum(req_tdata);
                  phase = GET_ID;
               end
               GET_ID: begin
                  frame_id = req_tdata;
                  add_to_checksum(req_tdata);
                  phase = GET_LEN_LO;
               end
               GET_LEN_LO: begin
                  frame_len = {8'd0, req_tdata};
                  add_to_checksum(req_tdata);
                  phase = GET_LEN_HI;
               end
               GET_LEN_HI: begin
                  frame_len[15:8] = req_tdata;
                  add_to_checksum(req_tdata);
                  byte_count = '0;
                  if (frame_len == 16'd0) phase = CHECK_CK_A;
                  else if (frame_len <= PAYLOAD_BYTES) phase = GET_PAYLOAD;
                  else clear_parser();
               end
               GET_PAYLOAD: begin
                  if (byte_count < PAYLOAD_BYTES) payload[byte_count] = req_tdata;
                  add_to_checksum(req_tdata);
                  byte_count = byte_count + 7'd1;
                  if (byte_count >= frame_len || byte_count >= PAYLOAD_BYTES)
                     phase = CHECK_CK_A;
               end
               CHECK_CK_A: begin
                  if (req_tdata == sum_a) phase = CHECK_CK_B;
                  else clear_parser();
               end
               CHECK_CK_B: begin
                  if (req_tdata == sum_b && frame_class == NAV_CLASS &&
                      frame_id == PVT_ID && frame_len == PVT_LEN) begin
                     for (int k = 0; k < NUM_FIELDS; k++) begin
                        raw  = '0;
                        size = FIELD_BYTES[k];
                        for (int i = 0; i < size; i++)
                           raw = raw | (64'(payload[FIELD_OFFSET[k] + i]) << (8 * i));
                        if (FIELD_SIGNED[k] && raw[8 * size - 1])
                           raw = raw | ~((64'd1 << (8 * size)) - 64'd1);
                        field.index = 6'(k);
                        field.value = raw[32:0];
                        field.last  = 1'b0;
                        expected_fields.push_back(field);
                     end
                     field.index = FIX_INDEX;
                     field.value = {32'd0, payload[FIX_TYPE_OFF] >= MIN_FIX &&
                                           payload[FLAGS_OFF][0]};
                     field.last  = 1'b1;
                     expected_fields.push_back(field);
                  end
                  clear_parser();
               end
               default: clear_parser();
            endcase
         end
      end
      fields_pending = expected_fields.size();
   end

endmodule

/* tb/sv/ubx_nav_pvt_deframer_tb.sv */
`timescale 1ns / 1ps

module ubx_nav_pvt_deframer_tb;
   import ubx_pkg::*;

   localparam int PAYLOAD_BYTES = 92;
   localparam int TOTAL_BYTES   = 410;
   localparam int STALL_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 300;

   typedef enum int {CK_INTACT, CK_A_CORRUPT, CK_B_CORRUPT} check_fault_e;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = 8'd0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [39:0] rsp_tdata;
   logic [5:0]  rsp_tuser;
   logic        rsp_tlast;

   int          error_count;
   int          fields_pending;
   int          idle_cycles = 0;
   int          burst_left  = 0;
   int          bytes_sent  = 0;
   bit          gaps_on     = 1'b0;
   bit          hold_armed  = 1'b0;
   bit          hold_done   = 1'b0;
   logic [7:0]  frame_body [0:PAYLOAD_BYTES-1];
   logic [7:0]  run_ck_a;
   logic [7:0]  run_ck_b;

   always #5 clock = ~clock;

   ubx_nav_pvt_deframer #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   ubx_nav_pvt_deframer_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .error_count    (error_count),
      .fields_pending (fields_pending)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL ubx_nav_pvt_deframer");
            $finish;
         end
      end
   end

   // The receiver changes its stall pattern after each span of random length. Once armed, it
   // refuses the first field beat for a long stretch so that the block backs up.
   initial begin
      int mode;
      int span;
      while (reset) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(40, 200);
         repeat (span) begin
            if (hold_armed && !hold_done && rsp_tvalid) begin
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_done = 1'b1;
            end
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap        = $urandom_range(1, 12);
         burst_left = $urandom_range(1, 24);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (burst_left > 0) burst_left--;
      bytes_sent++;
   endtask

   task automatic send_summed(input logic [7:0] b);
      run_ck_a = run_ck_a + b;
      run_ck_b = run_ck_b + run_ck_a;
      send_byte(b);
   endtask

   // A length above the payload size ends the frame after its header.
   task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input check_fault_e fault);
      logic [7:0] ck_a;
      logic [7:0] ck_b;
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      run_ck_a = '0;
      run_ck_b = '0;
      send_summed(cls);
      send_summed(id);
      send_summed(len[7:0]);
      send_summed(len[15:8]);
      if (len > PAYLOAD_BYTES) return;
      for (int i = 0; i < len; i++) send_summed(frame_body[i]);
      ck_a = run_ck_a;
      ck_b = run_ck_b;
      if (fault == CK_A_CORRUPT) ck_a = ck_a ^ 8'($urandom_range(1, 255));
      if (fault == CK_B_CORRUPT) ck_b = ck_b ^ 8'($urandom_range(1, 255));
      send_byte(ck_a);
      send_byte(ck_b);
   endtask

   task automatic fill_body(input bit scramble, input logic [7:0] value);
      for (int i = 0; i < PAYLOAD_BYTES; i++)
         frame_body[i] = scramble ? 8'($urandom) : value;
      if (scramble && $urandom_range(0, 1))
         frame_body[FIX_TYPE_OFF] = 8'($urandom_range(0, 3));
   endtask

   initial begin
      int pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC_SECOND);
      send_byte(SYNC_FIRST);
      send_byte(8'h00);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      fill_body(1'b0, 8'hFF);
      send_frame(NAV_CLASS, PVT_ID, PVT_LEN, CK_INTACT);
      hold_armed = 1'b1;
      send_frame(8'h0A, 8'h04, 16'd0, CK_INTACT);
      send_frame(8'h0A, 8'h04, 16'd0, CK_A_CORRUPT);
      send_frame(NAV_CLASS, PVT_ID, 16'd93, CK_INTACT);
      send_frame(8'hFF, 8'hFF, 16'hFFFF, CK_INTACT);
      fill_body(1'b1, 8'h00);
      send_frame(NAV_CLASS, PVT_ID, PVT_LEN, CK_B_CORRUPT);

      while (bytes_sent < TOTAL_BYTES) begin
         pick    = $urandom_range(0, 99);
         gaps_on = ($urandom_range(0, 3) != 0);
         fill_body(1'b1, 8'h00);
         if (pick < 50) begin
            send_frame(NAV_CLASS, PVT_ID, PVT_LEN, CK_INTACT);
         end else if (pick < 60) begin
            send_frame(NAV_CLASS, PVT_ID, PVT_LEN,
                       check_fault_e'($urandom_range(0, 1) ? CK_A_CORRUPT
                                                            : CK_B_CORRUPT));
         end else if (pick < 72) begin
            send_frame(8'($urandom), 8'($urandom),
                       $urandom_range(0, 3) ? 16'($urandom_range(0, 12))
                                            : 16'($urandom_range(0, PAYLOAD_BYTES)),
                       check_fault_e'($urandom_range(0, 3) ? CK_INTACT
                                                            : CK_B_CORRUPT));
         end else if (pick < 80) begin
            send_frame(8'($urandom), 8'($urandom),
                       16'($urandom_range(PAYLOAD_BYTES + 1, 65535)), CK_INTACT);
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 3))
                  0: send_byte(SYNC_FIRST);
                  1: send_byte(SYNC_SECOND);
                  default: send_byte(8'($urandom));
               endcase
            end
         end else begin
            send_byte(SYNC_FIRST);
            send_byte($urandom_range(0, 1) ? SYNC_FIRST : 8'($urandom_range(0, 8'h61)));
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (fields_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS ubx_nav_pvt_deframer");
      end else begin
         $display("FAIL ubx_nav_pvt_deframer");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/ubx_pkg.sv
hdl/ubx_ram.sv
hdl/ubx_ctrl.sv
hdl/ubx_dp.sv
hdl/ubx_nav_pvt_deframer.sv
hdl/ubx_chk.sv
tb/sv/ubx_nav_pvt_deframer_checker.sv
tb/sv/ubx_nav_pvt_deframer_tb.sv
